### hdl/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

    // field and state widths
    localparam int CNT_W     = 24;                 // frame counts, COUNT_WIDTH
    localparam int FRAC_W    = 16;                 // beat fraction bits
    localparam int INT_W     = 24;                 // beat integer bits
    localparam int BEAT_W    = INT_W + FRAC_W;     // Q24.16 beat
    localparam int REP_W     = 32;                 // repeat count
    localparam int PER_W     = 31;                 // retrigger period
    localparam int SB_W      = 7;                  // sync beats
    localparam int SYNC_W    = 32;                 // signed sync countdown
    localparam int STEP_W    = CNT_W + 2;          // step countdown
    localparam int CMD_W     = 2;

    // iterative unit widths
    localparam int MAG_W     = BEAT_W + 1;         // magnitude of beat difference
    localparam int DIFF_W    = BEAT_W + 2;         // signed beat difference
    localparam int ALU_W     = MAG_W + 1;          // shared adder width
    localparam int OPND_W    = (PER_W > CNT_W) ? PER_W : CNT_W;
    localparam int LO_W      = (REP_W > STEP_W) ? REP_W : STEP_W;
    localparam int PROD_W    = ALU_W + CNT_W;
    localparam int DIV_STEPS = LO_W;
    localparam int MUL_STEPS = CNT_W;
    localparam int STEPS_W   = $clog2(DIV_STEPS + 1);

    // configuration port
    localparam int CFG_W     = (OPND_W > SB_W) ? OPND_W : SB_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_FRAMES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_FRAMES     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ON          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRIGGER_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRIGGER_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_FRAMES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BEATS       = 3'd6;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd3;

    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;

    localparam logic [SYNC_W-1:0] SYNC_MAX = {1'b0, {(SYNC_W-1){1'b1}}};
    localparam logic [SYNC_W-1:0] SYNC_MIN = {1'b1, {(SYNC_W-1){1'b0}}};

    localparam logic [CNT_W-1:0] RST_FRAMES     = CNT_W'(1);
    localparam logic [PER_W-1:0] RST_PERIOD     = {PER_W{1'b1}};
    localparam logic [SB_W-1:0]  RST_SYNC_BEATS = SB_W'(4);

    typedef struct packed {
        logic [CNT_W-1:0] step_frames;
        logic [CNT_W-1:0] slice_frames;
        logic             sync_on;
        logic             retrigger_on;
        logic [PER_W-1:0] retrigger_period;
        logic [CNT_W-1:0] beat_frames;
        logic [SB_W-1:0]  sync_beats;
    } t_cfg;

    // request to the shared unit: divide gives a mod b, multiply gives a * b
    typedef struct packed {
        logic              start;
        logic              op;
        logic [MAG_W-1:0]  a;
        logic [OPND_W-1:0] b;
    } t_iter_req;

    typedef struct packed {
        logic             done;
        logic [ALU_W-1:0] acc;
        logic [LO_W-1:0]  lo;
    } t_iter_rsp;

endpackage

### hdl/srt_regs.sv
`timescale 1ns / 1ps

module srt_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srt_pkg::CFG_W-1:0]      i_cfg_data,
    output srt_pkg::t_cfg                  o_cfg
);
    import srt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP_FRAMES:      n_cfg.step_frames      = i_cfg_data[CNT_W-1:0];
                REG_SLICE_FRAMES:     n_cfg.slice_frames     = i_cfg_data[CNT_W-1:0];
                REG_SYNC_ON:          n_cfg.sync_on          = i_cfg_data[0];
                REG_RETRIGGER_ON:     n_cfg.retrigger_on     = i_cfg_data[0];
                REG_RETRIGGER_PERIOD: n_cfg.retrigger_period = i_cfg_data[PER_W-1:0];
                REG_BEAT_FRAMES:      n_cfg.beat_frames      = i_cfg_data[CNT_W-1:0];
                REG_SYNC_BEATS:       n_cfg.sync_beats       = i_cfg_data[SB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_frames      <= RST_FRAMES;
            r_cfg.slice_frames     <= RST_FRAMES;
            r_cfg.sync_on          <= 1'b0;
            r_cfg.retrigger_on     <= 1'b0;
            r_cfg.retrigger_period <= RST_PERIOD;
            r_cfg.beat_frames      <= RST_FRAMES;
            r_cfg.sync_beats       <= RST_SYNC_BEATS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/srt_iter.sv
`timescale 1ns / 1ps

module srt_iter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srt_pkg::t_iter_req  i_req,
    output srt_pkg::t_iter_rsp  o_rsp
);
    import srt_pkg::*;

    logic               r_busy,  n_busy;
    logic               r_done,  n_done;
    logic               r_op,    n_op;
    logic [STEPS_W-1:0] r_cnt,   n_cnt;
    logic [ALU_W-1:0]   r_acc,   n_acc;
    logic [LO_W-1:0]    r_lo,    n_lo;
    logic [ALU_W-1:0]   r_opnd,  n_opnd;

    logic [ALU_W-1:0]   rem_sh;
    logic [ALU_W-1:0]   add_a;
    logic [ALU_W-1:0]   add_b;
    logic               add_sub;
    logic [ALU_W:0]     add_sum;

    // one shared adder: restoring divide subtracts, shift-add multiply adds
    assign rem_sh  = {r_acc[ALU_W-2:0], r_lo[LO_W-1]};
    assign add_sub = (r_op == OP_DIV);
    assign add_a   = add_sub ? rem_sh : r_acc;
    assign add_b   = add_sub ? ~r_opnd : (r_lo[0] ? r_opnd : '0);
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (ALU_W+1)'(add_sub);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_lo   = r_lo;
        n_opnd = r_opnd;
        if (r_busy) begin
            n_cnt = r_cnt - STEPS_W'(1);
            if (r_cnt == STEPS_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            if (r_op == OP_DIV) begin
                n_lo  = {r_lo[LO_W-2:0], 1'b0};
                n_acc = add_sum[ALU_W] ? add_sum[ALU_W-1:0] : rem_sh;
            end else begin
                n_acc = add_sum[ALU_W:1];
                n_lo  = {add_sum[0], r_lo[LO_W-1:1]};
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_acc  = '0;
            if (i_req.op == OP_DIV) begin
                n_cnt  = STEPS_W'(DIV_STEPS);
                n_lo   = i_req.a[LO_W-1:0];
                n_opnd = ALU_W'(i_req.b);
            end else begin
                n_cnt  = STEPS_W'(MUL_STEPS);
                n_lo   = LO_W'(i_req.b[CNT_W-1:0]);
                n_opnd = ALU_W'(i_req.a);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_lo   <= n_lo;
        r_opnd <= n_opnd;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.acc  = r_acc;
    assign o_rsp.lo   = r_lo;

endmodule

### hdl/slice_retrigger_timer.sv
`timescale 1ns / 1ps
// slice retrigger timer
// input channel: i_in_valid / o_in_ready carry one item, a command and a
// Q24.16 beat position; command 0 is a frame tick, 1 loads the sync
// countdown, 2 starts the timer at a beat, 3 resets the timer
// output channel: o_out_valid / i_out_ready carry one result item per input
// item: slice fire, forced forward play, slice length, repeat total, running
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at once
// one item is handled at a time by a small sequencer around a shared
// shift-add / restoring-divide unit (one add per cycle): start and reset
// commands go straight to the output state, a sync load runs a 24-step
// multiply, and a tick walks the sync and step countdowns, adding a 32-step
// divide to realign on sync expiry and another to check the retrigger period
// the finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result then waits until it is free
// reset (synchronous, active low) clears the timer state and loads the
// register defaults; no item is in flight afterward
module slice_retrigger_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [srt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srt_pkg::CFG_W-1:0]       i_cfg_data,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [srt_pkg::CMD_W-1:0]       i_command,
    input  logic [srt_pkg::BEAT_W-1:0]      i_beat_position,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_slice_fire,
    output logic                            o_force_forward,
    output logic [srt_pkg::CNT_W-1:0]       o_slice_length,
    output logic [srt_pkg::REP_W-1:0]       o_repeat_total,
    output logic                            o_is_running
);
    import srt_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LD_MUL   = 3'd1;   // start beat difference times frames
    localparam logic [2:0] S_LD_WAIT  = 3'd2;
    localparam logic [2:0] S_TK_SYNC  = 3'd3;   // sync countdown, maybe start rounding
    localparam logic [2:0] S_RND_WAIT = 3'd4;
    localparam logic [2:0] S_TK_STEP  = 3'd5;   // step countdown, maybe start period check
    localparam logic [2:0] S_MOD_WAIT = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;   // hand result to output register

    t_cfg      cfg;
    t_iter_req req;
    t_iter_rsp rsp;

    logic [2:0]        r_state,   n_state;
    logic [STEP_W-1:0] r_step_cd, n_step_cd;
    logic [REP_W-1:0]  r_repeat,  n_repeat;
    logic [SYNC_W-1:0] r_sync_cd, n_sync_cd;
    logic [BEAT_W-1:0] r_last,    n_last;
    logic              r_running, n_running;
    logic [DIFF_W-1:0] r_diff,    n_diff;
    logic              r_fire,    n_fire;
    logic              r_fwd,     n_fwd;

    logic              r_out_valid, n_out_valid;
    logic              r_o_fire,    n_o_fire;
    logic              r_o_fwd,     n_o_fwd;
    logic [CNT_W-1:0]  r_o_len,     n_o_len;
    logic [REP_W-1:0]  r_o_rep,     n_o_rep;
    logic              r_o_run,     n_o_run;

    logic                 in_take;
    logic [BEAT_W-1:0]    sync_step;
    logic [MAG_W-1:0]     diff_mag;
    logic [SYNC_W-1:0]    sync_dec;
    logic                 sync_expired;
    logic [CNT_W-1:0]     rnd_rem;
    logic                 rnd_up;
    logic [STEP_W-1:0]    rnd_val;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-FRAC_W-1:0] scaled;
    logic                 scaled_over;
    logic [SYNC_W-1:0]    load_val;

    srt_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    srt_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;

    // sync_beats as a Q24.16 beat count
    assign sync_step = BEAT_W'({cfg.sync_beats, {FRAC_W{1'b0}}});

    // |last + sync_beats - pos|, always below 2^41
    assign diff_mag = r_diff[DIFF_W-1] ? MAG_W'(~r_diff + DIFF_W'(1)) : MAG_W'(r_diff);

    // sync countdown decrement saturates at the signed minimum
    assign sync_dec     = (r_sync_cd == SYNC_MIN) ? r_sync_cd : r_sync_cd - SYNC_W'(1);
    assign sync_expired = sync_dec[SYNC_W-1] || (sync_dec == '0);

    // nearest multiple of step length, halves away from zero:
    // x - r, plus one step when 2r >= s
    assign rnd_rem = rsp.acc[CNT_W-1:0];
    assign rnd_up  = ({rnd_rem, 1'b0} >= {1'b0, cfg.step_frames});
    assign rnd_val = r_step_cd - STEP_W'(rnd_rem)
                   + (rnd_up ? STEP_W'(cfg.step_frames) : '0);

    // product of difference and beat_frames, fraction dropped, saturated
    assign prod        = {rsp.acc, rsp.lo[LO_W-1 -: CNT_W]};
    assign scaled      = prod[PROD_W-1:FRAC_W];
    assign scaled_over = |scaled[PROD_W-FRAC_W-1:SYNC_W-1];
    always_comb begin
        if (r_diff[DIFF_W-1]) begin
            load_val = scaled_over ? SYNC_MIN : (~scaled[SYNC_W-1:0] + SYNC_W'(1));
        end else begin
            load_val = scaled_over ? SYNC_MAX : scaled[SYNC_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step_cd   = r_step_cd;
        n_repeat    = r_repeat;
        n_sync_cd   = r_sync_cd;
        n_last      = r_last;
        n_running   = r_running;
        n_diff      = r_diff;
        n_fire      = r_fire;
        n_fwd       = r_fwd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_fire    = r_o_fire;
        n_o_fwd     = r_o_fwd;
        n_o_len     = r_o_len;
        n_o_rep     = r_o_rep;
        n_o_run     = r_o_run;
        req.start   = 1'b0;
        req.op      = OP_DIV;
        req.a       = MAG_W'(r_step_cd);
        req.b       = OPND_W'(cfg.step_frames);

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_fire = 1'b0;
                    n_fwd  = 1'b0;
                    unique case (i_command)
                        CMD_TICK: n_state = S_TK_SYNC;
                        CMD_LOAD: begin
                            n_diff  = DIFF_W'(r_last) + DIFF_W'(sync_step)
                                    - DIFF_W'(i_beat_position);
                            n_state = S_LD_MUL;
                        end
                        CMD_START: begin
                            n_last    = i_beat_position;
                            n_running = 1'b1;
                            n_state   = S_OUT;
                        end
                        default: begin
                            n_running = 1'b0;
                            n_step_cd = '0;
                            n_repeat  = '0;
                            n_state   = S_OUT;
                        end
                    endcase
                end
            end
            S_LD_MUL: begin
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.a     = diff_mag;
                req.b     = OPND_W'(cfg.beat_frames);
                n_state   = S_LD_WAIT;
            end
            S_LD_WAIT: begin
                if (rsp.done) begin
                    n_sync_cd = load_val;
                    n_state   = S_OUT;
                end
            end
            S_TK_SYNC: begin
                n_state = S_TK_STEP;
                if (cfg.sync_on) begin
                    n_sync_cd = sync_dec;
                    if (sync_expired) begin
                        n_last = r_last + sync_step;
                        if (cfg.step_frames == '0) begin
                            // zero step length rounds to zero
                            n_step_cd = STEP_W'(1);
                        end else begin
                            req.start = 1'b1;
                            n_state   = S_RND_WAIT;
                        end
                    end
                end
            end
            S_RND_WAIT: begin
                if (rsp.done) begin
                    n_step_cd = rnd_val + STEP_W'(1);
                    n_state   = S_TK_STEP;
                end
            end
            S_TK_STEP: begin
                n_state = S_OUT;
                if (r_step_cd <= STEP_W'(1)) begin
                    // countdown reaches zero or below: fire and reload
                    n_fire    = 1'b1;
                    n_step_cd = STEP_W'(cfg.step_frames);
                    if (cfg.retrigger_on && (cfg.retrigger_period != '0)) begin
                        req.start = 1'b1;
                        req.a     = MAG_W'(r_repeat);
                        req.b     = OPND_W'(cfg.retrigger_period);
                        n_state   = S_MOD_WAIT;
                    end else begin
                        n_repeat = r_repeat + REP_W'(1);
                    end
                end else begin
                    n_step_cd = r_step_cd - STEP_W'(1);
                end
            end
            S_MOD_WAIT: begin
                if (rsp.done) begin
                    n_fwd    = (rsp.acc == '0);
                    n_repeat = r_repeat + REP_W'(1);
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_fire    = r_fire;
                    n_o_fwd     = r_fwd;
                    n_o_len     = r_fire ? cfg.slice_frames : '0;
                    n_o_rep     = r_repeat;
                    n_o_run     = r_running;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_cd   <= '0;
            r_repeat    <= '0;
            r_sync_cd   <= '0;
            r_last      <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step_cd   <= n_step_cd;
            r_repeat    <= n_repeat;
            r_sync_cd   <= n_sync_cd;
            r_last      <= n_last;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
        r_diff  <= n_diff;
        r_fire  <= n_fire;
        r_fwd   <= n_fwd;
        r_o_fire <= n_o_fire;
        r_o_fwd  <= n_o_fwd;
        r_o_len  <= n_o_len;
        r_o_rep  <= n_o_rep;
        r_o_run  <= n_o_run;
    end

    assign o_out_valid     = r_out_valid;
    assign o_slice_fire    = r_o_fire;
    assign o_force_forward = r_o_fwd;
    assign o_slice_length  = r_o_len;
    assign o_repeat_total  = r_o_rep;
    assign o_is_running    = r_o_run;

endmodule
